FILE: hdl/psv_pkg.sv
// Shared types, constants and helper functions for the period-sum voltage readout.
// Used by psv_gather, psv_div and period_sum_voltage_readout_core; depends on nothing.
`default_nettype none

package psv_pkg;

  // Width of the saturating period sum.
  localparam int SUM_W = 32;
  // Accumulator width: one guard bit above the wider of the sum and the tick field.
  localparam int ACC_W = ((SUM_W > 32) ? SUM_W : 32) + 1;
  // Divisor width of the shared divider: it must take the period sum and 31-bit registers.
  localparam int DVS_W = (SUM_W > 32) ? SUM_W : 32;
  // The dividend and quotient are always 32 bits, one quotient bit per step.
  localparam int QUO_W = 32;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam int LIMIT_W = 16;
  localparam int CAL_W = 31;
  localparam int DATA_W = 32;
  localparam int IDX_W = 3;

  localparam logic [LIMIT_W-1:0] EDGE_LIMIT_RST = 16'd1000;
  localparam logic [CAL_W-1:0] CAL_NUMERATOR_RST = 31'd43756800;
  localparam logic [CAL_W-1:0] CAL_OFFSET_RST = 31'd10000000;
  localparam logic [CAL_W-1:0] CAL_SLOPE_RST = 31'd19600;
  localparam logic [CAL_W-1:0] CAL_DIVISOR_RST = 31'd60348;

  localparam logic [DATA_W-1:0] SCALE_MILLI = 32'd1000;
  localparam logic [DATA_W-1:0] SCALE_TEN = 32'd10;

  typedef enum logic [IDX_W-1:0] {
    REG_EDGE_LIMIT    = 3'd0,
    REG_CAL_NUMERATOR = 3'd1,
    REG_CAL_OFFSET    = 3'd2,
    REG_CAL_SLOPE     = 3'd3,
    REG_CAL_DIVISOR   = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_EDGE    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_MUL_A,
    ST_DIV_B_GO,
    ST_DIV_B,
    ST_MUL_B,
    ST_DIV_C_GO,
    ST_DIV_C,
    ST_MUL_C,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  // Magnitude of a two's complement word; the most negative value maps onto itself.
  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
    magnitude = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
  endfunction

  function automatic logic [DATA_W-1:0] apply_sign(input logic [DATA_W-1:0] x,
                                                   input logic neg);
    apply_sign = neg ? (~x + DATA_W'(1)) : x;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/psv_gather.sv
// Period gathering: saturating period sum, wrapping edge count and gathering flag.
// Depends on psv_pkg.
`default_nettype none

module psv_gather (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         edge_en,
  input  wire logic                         clear,
  input  wire logic [31:0]                  ticks,
  input  wire logic [psv_pkg::LIMIT_W-1:0]  edge_limit,
  output logic      [psv_pkg::SUM_W-1:0]    period_sum
);

  logic [psv_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [psv_pkg::LIMIT_W-1:0] count_r, count_nxt;
  logic                        gathering_r, gathering_nxt;
  logic [psv_pkg::ACC_W-1:0]   acc;
  logic [psv_pkg::LIMIT_W-1:0] count_inc;

  assign acc = psv_pkg::ACC_W'(sum_r) + psv_pkg::ACC_W'(ticks);
  assign count_inc = count_r + psv_pkg::LIMIT_W'(1);

  always_comb begin
    sum_nxt = sum_r;
    count_nxt = count_r;
    gathering_nxt = gathering_r;
    if (clear) begin
      sum_nxt = '0;
      gathering_nxt = 1'b1;
    end else if (edge_en && gathering_r) begin
      // Anything above the sum width saturates to all ones.
      if (acc[psv_pkg::ACC_W-1:psv_pkg::SUM_W] != '0) begin
        sum_nxt = '1;
      end else begin
        sum_nxt = acc[psv_pkg::SUM_W-1:0];
      end
      if (count_inc == edge_limit) begin
        count_nxt = '0;
        gathering_nxt = 1'b0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      count_r <= '0;
      gathering_r <= 1'b1;
    end else begin
      sum_r <= sum_nxt;
      count_r <= count_nxt;
      gathering_r <= gathering_nxt;
    end
  end

  assign period_sum = sum_r;

endmodule

`default_nettype wire

FILE: hdl/psv_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on psv_pkg for widths and the request/response structs.
`default_nettype none

module psv_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire psv_pkg::div_req_t req,
  output psv_pkg::div_rsp_t      rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [psv_pkg::STEP_W-1:0]   step_r;
  logic [psv_pkg::DVS_W-1:0]    rem_r;
  logic [psv_pkg::QUO_W-1:0]    quo_r;
  logic [psv_pkg::DVS_W-1:0]    dvs_r;
  logic [psv_pkg::DVS_W:0]      rem_sh;
  logic [psv_pkg::DVS_W+1:0]    trial;
  logic                         fits;
  logic                         last_step;

  // The partial remainder stays below the divisor, so one extra bit holds the shift.
  assign rem_sh = {rem_r, quo_r[psv_pkg::QUO_W-1]};
  assign trial = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits = ~trial[psv_pkg::DVS_W+1];
  assign last_step = (step_r == psv_pkg::STEP_W'(psv_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + psv_pkg::STEP_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[psv_pkg::DVS_W-1:0] : rem_sh[psv_pkg::DVS_W-1:0];
      quo_r <= {quo_r[psv_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while a division is running");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

`default_nettype wire

FILE: hdl/period_sum_voltage_readout_core.sv
// Top level of the period-sum voltage readout: stream ports, calibration registers,
// conversion sequencer with a shared multiplier. Uses psv_pkg, psv_gather and psv_div.
`default_nettype none

// An edge transfer (in_tuser = 0) is taken while the core is idle and adds its tick
// count to the period sum while gathering is on; it gives no result. A convert transfer
// (in_tuser = 1) runs three 32-step divisions one after another on the single radix-2
// divider, each followed by a multiply state, and the input side is not ready until the
// result has been loaded into the output register. A conversion with a zero period sum
// returns at once with the error flag.
// cfg_ready is always high; write the calibration registers only while no conversion is
// running and no result is pending.
module period_sum_voltage_readout_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [31:0]                 in_tdata,   // [31:0] elapsed_ticks
  input  wire logic                        in_tuser,   // [0] command
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [31:0]                 out_tdata,  // [31:0] voltage_mv, signed
  output logic                             out_tuser,  // [0] div_error
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [psv_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [psv_pkg::DATA_W-1:0]  cfg_data
);

  logic [psv_pkg::LIMIT_W-1:0] edge_limit_r;
  logic [psv_pkg::CAL_W-1:0]   cal_numerator_r;
  logic [psv_pkg::CAL_W-1:0]   cal_offset_r;
  logic [psv_pkg::CAL_W-1:0]   cal_slope_r;
  logic [psv_pkg::CAL_W-1:0]   cal_divisor_r;

  psv_pkg::state_t             state_r, state_nxt;
  logic [psv_pkg::DATA_W-1:0]  op_r;
  logic [psv_pkg::DATA_W-1:0]  prod_r;
  logic                        neg_r;
  logic                        err_r;
  logic                        out_valid_r;
  logic [psv_pkg::DATA_W-1:0]  out_data_r;
  logic                        out_err_r;

  logic                        in_xfer;
  logic                        edge_en;
  logic                        conv_en;
  logic [psv_pkg::SUM_W-1:0]   period_sum;
  psv_pkg::div_req_t           div_req;
  psv_pkg::div_rsp_t           div_rsp;
  logic [psv_pkg::DATA_W-1:0]  diff;
  logic [psv_pkg::DATA_W-1:0]  signed_quo;
  logic [psv_pkg::DATA_W-1:0]  mul_x, mul_y, mul_p;
  logic                        mul_en;
  logic                        out_free;
  logic                        out_load;
  logic                        bad_a;

  assign cfg_ready = 1'b1;
  assign in_xfer = in_tvalid && in_tready;
  assign edge_en = in_xfer && (psv_pkg::cmd_t'(in_tuser) == psv_pkg::CMD_EDGE);
  assign conv_en = in_xfer && (psv_pkg::cmd_t'(in_tuser) == psv_pkg::CMD_CONVERT);
  assign out_free = !out_valid_r || out_tready;
  assign diff = {1'b0, cal_offset_r} - prod_r;
  assign signed_quo = psv_pkg::apply_sign(div_rsp.quotient, neg_r);
  assign bad_a = (div_rsp.quotient == '0) || (cal_divisor_r == '0);
  assign mul_p = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_limit_r <= psv_pkg::EDGE_LIMIT_RST;
      cal_numerator_r <= psv_pkg::CAL_NUMERATOR_RST;
      cal_offset_r <= psv_pkg::CAL_OFFSET_RST;
      cal_slope_r <= psv_pkg::CAL_SLOPE_RST;
      cal_divisor_r <= psv_pkg::CAL_DIVISOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (psv_pkg::reg_idx_t'(cfg_index))
        psv_pkg::REG_EDGE_LIMIT:    edge_limit_r <= cfg_data[psv_pkg::LIMIT_W-1:0];
        psv_pkg::REG_CAL_NUMERATOR: cal_numerator_r <= cfg_data[psv_pkg::CAL_W-1:0];
        psv_pkg::REG_CAL_OFFSET:    cal_offset_r <= cfg_data[psv_pkg::CAL_W-1:0];
        psv_pkg::REG_CAL_SLOPE:     cal_slope_r <= cfg_data[psv_pkg::CAL_W-1:0];
        psv_pkg::REG_CAL_DIVISOR:   cal_divisor_r <= cfg_data[psv_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // A conversion clears the sum as it is accepted; the divider has latched it by then.
  psv_gather u_gather (
    .clk        (clk),
    .rst_n      (rst_n),
    .edge_en    (edge_en),
    .clear      (conv_en),
    .ticks      (in_tdata),
    .edge_limit (edge_limit_r),
    .period_sum (period_sum)
  );

  psv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psv_pkg::ST_IDLE: begin
        if (conv_en) begin
          state_nxt = (period_sum == '0) ? psv_pkg::ST_OUT : psv_pkg::ST_DIV_A;
        end
      end
      psv_pkg::ST_DIV_A: begin
        if (div_rsp.done) begin
          state_nxt = bad_a ? psv_pkg::ST_OUT : psv_pkg::ST_MUL_A;
        end
      end
      psv_pkg::ST_MUL_A:    state_nxt = psv_pkg::ST_DIV_B_GO;
      psv_pkg::ST_DIV_B_GO: state_nxt = psv_pkg::ST_DIV_B;
      psv_pkg::ST_DIV_B: begin
        if (div_rsp.done) begin
          state_nxt = psv_pkg::ST_MUL_B;
        end
      end
      psv_pkg::ST_MUL_B:    state_nxt = psv_pkg::ST_DIV_C_GO;
      psv_pkg::ST_DIV_C_GO: state_nxt = psv_pkg::ST_DIV_C;
      psv_pkg::ST_DIV_C: begin
        if (div_rsp.done) begin
          state_nxt = psv_pkg::ST_MUL_C;
        end
      end
      psv_pkg::ST_MUL_C:    state_nxt = psv_pkg::ST_OUT;
      psv_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = psv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    mul_x = op_r;
    mul_y = '0;
    mul_en = 1'b0;
    out_load = 1'b0;
    case (state_r)
      psv_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        // The input is always ready here, so a valid convert request is a transfer.
        div_req.start = in_tvalid &&
                        (psv_pkg::cmd_t'(in_tuser) == psv_pkg::CMD_CONVERT) &&
                        (period_sum != '0);
        div_req.dividend = {1'b0, cal_numerator_r};
        div_req.divisor = psv_pkg::DVS_W'(period_sum);
      end
      psv_pkg::ST_MUL_A: begin
        mul_y = {1'b0, cal_slope_r};
        mul_en = 1'b1;
      end
      psv_pkg::ST_DIV_B_GO: begin
        div_req.start = 1'b1;
        div_req.dividend = psv_pkg::magnitude(diff);
        div_req.divisor = psv_pkg::DVS_W'(op_r);
      end
      psv_pkg::ST_MUL_B: begin
        mul_y = psv_pkg::SCALE_MILLI;
        mul_en = 1'b1;
      end
      psv_pkg::ST_DIV_C_GO: begin
        div_req.start = 1'b1;
        div_req.dividend = psv_pkg::magnitude(prod_r);
        div_req.divisor = psv_pkg::DVS_W'(cal_divisor_r);
      end
      psv_pkg::ST_MUL_C: begin
        mul_y = psv_pkg::SCALE_TEN;
        mul_en = 1'b1;
      end
      psv_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psv_pkg::ST_IDLE;
      err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (conv_en) begin
        err_r <= (period_sum == '0);
      end else if ((state_r == psv_pkg::ST_DIV_A) && div_rsp.done) begin
        err_r <= bad_a;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: operand, product, sign of the running division, result.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    if (div_rsp.done) begin
      op_r <= (state_r == psv_pkg::ST_DIV_A) ? div_rsp.quotient : signed_quo;
    end
    if (state_r == psv_pkg::ST_DIV_B_GO) begin
      neg_r <= diff[psv_pkg::DATA_W-1];
    end else if (state_r == psv_pkg::ST_DIV_C_GO) begin
      neg_r <= prod_r[psv_pkg::DATA_W-1];
    end
    if (out_load) begin
      out_data_r <= err_r ? '0 : prod_r;
      out_err_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("error result carries a nonzero voltage");

  a_second_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psv_pkg::ST_DIV_B_GO) |-> (op_r != '0))
    else $error("second division started with a zero divisor");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    conv_en |=> !in_tready)
    else $error("input taken while a conversion is running");

endmodule

`default_nettype wire

FILE: test/period_sum_voltage_readout_core_tb.sv
// Self-checking testbench for period_sum_voltage_readout_core: edge and convert transfers
// with random idling, checked against an in-bench predictor held in a scoreboard class.
// Depends on psv_pkg and the RTL of period_sum_voltage_readout_core only.

module period_sum_voltage_readout_core_tb;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam logic [31:0] CAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] LIMIT_MAX = 32'h0000_FFFF;

  typedef struct {
    logic [31:0] mv;
    logic        err;
  } reading_t;

  class readout_scoreboard;
    logic [psv_pkg::LIMIT_W-1:0] edge_limit;
    logic [psv_pkg::CAL_W-1:0]   numerator;
    logic [psv_pkg::CAL_W-1:0]   offset;
    logic [psv_pkg::CAL_W-1:0]   slope;
    logic [psv_pkg::CAL_W-1:0]   divisor;
    logic [psv_pkg::SUM_W-1:0]   period_sum;
    logic [psv_pkg::LIMIT_W-1:0] edge_count;
    logic                        gathering;
    reading_t                    pending[$];
    int                          fails;

    function new();
      edge_limit = psv_pkg::EDGE_LIMIT_RST;
      numerator = psv_pkg::CAL_NUMERATOR_RST;
      offset = psv_pkg::CAL_OFFSET_RST;
      slope = psv_pkg::CAL_SLOPE_RST;
      divisor = psv_pkg::CAL_DIVISOR_RST;
      period_sum = '0;
      edge_count = '0;
      gathering = 1'b1;
      fails = 0;
    endfunction

    function void set_reg(psv_pkg::reg_idx_t idx, logic [31:0] data);
      case (idx)
        psv_pkg::REG_EDGE_LIMIT:    edge_limit = data[psv_pkg::LIMIT_W-1:0];
        psv_pkg::REG_CAL_NUMERATOR: numerator = data[psv_pkg::CAL_W-1:0];
        psv_pkg::REG_CAL_OFFSET:    offset = data[psv_pkg::CAL_W-1:0];
        psv_pkg::REG_CAL_SLOPE:     slope = data[psv_pkg::CAL_W-1:0];
        psv_pkg::REG_CAL_DIVISOR:   divisor = data[psv_pkg::CAL_W-1:0];
        default: ;
      endcase
    endfunction

    // Signed division by a positive divisor, truncating toward zero.
    function logic [31:0] trunc_div(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag;
      mag = num[31] ? 32'd0 - num : num;
      mag = mag / den;
      return num[31] ? 32'd0 - mag : mag;
    endfunction

    function reading_t convert_voltage();
      reading_t                  r;
      logic [psv_pkg::DVS_W-1:0] quo;
      logic [31:0]               a;
      logic [31:0]               diff;
      logic [31:0]               b;
      logic [31:0]               c;
      r.mv = '0;
      r.err = 1'b0;
      if (period_sum == '0) begin
        r.err = 1'b1;
      end else begin
        quo = psv_pkg::DVS_W'(numerator) / psv_pkg::DVS_W'(period_sum);
        a = quo[31:0];
        if (a == '0 || divisor == '0) begin
          r.err = 1'b1;
        end else begin
          diff = {1'b0, offset} - a * {1'b0, slope};
          b = trunc_div(diff, a);
          c = trunc_div(b * psv_pkg::SCALE_MILLI, {1'b0, divisor});
          r.mv = c * psv_pkg::SCALE_TEN;
        end
      end
      return r;
    endfunction

    function void note_input(psv_pkg::cmd_t cmd, logic [31:0] ticks);
      logic [psv_pkg::ACC_W-1:0] acc;
      if (cmd == psv_pkg::CMD_CONVERT) begin
        pending.push_back(convert_voltage());
        period_sum = '0;
        gathering = 1'b1;
        return;
      end
      if (!gathering) return;
      acc = psv_pkg::ACC_W'(period_sum) + psv_pkg::ACC_W'(ticks);
      period_sum = (acc[psv_pkg::ACC_W-1:psv_pkg::SUM_W] != '0) ? '1 :
                   acc[psv_pkg::SUM_W-1:0];
      edge_count = edge_count + psv_pkg::LIMIT_W'(1);
      if (edge_count == edge_limit) begin
        gathering = 1'b0;
        edge_count = '0;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      fails++;
    endtask

    task check_result(logic [31:0] mv, logic err);
      reading_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with none expected: mv %0d err %0b", $signed(mv), err));
        return;
      end
      want = pending.pop_front();
      if (mv !== want.mv)
        report($sformatf("voltage_mv %0d, expected %0d", $signed(mv), $signed(want.mv)));
      if (err !== want.err)
        report($sformatf("div_error %0b, expected %0b", err, want.err));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [31:0]                in_tdata;   // [31:0] elapsed_ticks
  logic                       in_tuser;   // [0] command
  logic                       out_tvalid;
  logic                       out_tready;
  logic [31:0]                out_tdata;  // [31:0] voltage_mv, signed
  logic                       out_tuser;  // [0] div_error
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [psv_pkg::IDX_W-1:0]  cfg_index;
  logic [psv_pkg::DATA_W-1:0] cfg_data;

  readout_scoreboard sb;
  int  cycle_count = 0;
  int  live_items;
  int  burst_left;
  bit  gaps_on;
  int  holds_asked = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  int  rx_cycle = 0;
  int  rx_mode = 0;

  period_sum_voltage_readout_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** period_sum_voltage_readout_core: FAILED **");
      $finish;
    end
  end

  // Receiver: a stall pattern that changes every so often, plus long hold-offs on request.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= (rx_cycle % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic send_item(psv_pkg::cmd_t cmd, logic [31:0] ticks);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= ticks;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, ticks);
    live_items++;
  endtask

  // Lets every expected result arrive, then waits out a conversion that may still run.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(psv_pkg::reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic load_config(logic [31:0] lim, logic [31:0] num, logic [31:0] off,
                             logic [31:0] slp, logic [31:0] dvs);
    write_reg(psv_pkg::REG_EDGE_LIMIT, lim);
    write_reg(psv_pkg::REG_CAL_NUMERATOR, num);
    write_reg(psv_pkg::REG_CAL_OFFSET, off);
    write_reg(psv_pkg::REG_CAL_SLOPE, slp);
    write_reg(psv_pkg::REG_CAL_DIVISOR, dvs);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_ticks(int mode);
    case (mode)
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 65535);
      2: return $urandom;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_cal(logic [31:0] dflt, bit zero_ok);
    logic [31:0] v;
    v = $urandom & CAL_MAX;
    case ($urandom_range(0, 5))
      0: return CAL_MAX;
      1: return $urandom_range(1, 100);
      2: return dflt;
      3: return zero_ok ? 32'd0 : 32'd1;
      default: return (v == '0) ? 32'd1 : v;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom_range(1, 24);
      4: return LIMIT_MAX;
      5: return 32'd1;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  // A run of edges with one tick range, usually closed by a conversion.
  task automatic run_sequence();
    int n;
    int m;
    int mode;
    m = $urandom_range(0, 9);
    mode = (m < 4) ? 0 : (m < 7) ? 1 : (m < 9) ? 2 : 3;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) send_item(psv_pkg::CMD_EDGE, pick_ticks(mode));
    if ($urandom_range(0, 9) != 0) send_item(psv_pkg::CMD_CONVERT, $urandom);
  endtask

  initial begin
    int target;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = psv_pkg::CMD_EDGE;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = psv_pkg::REG_EDGE_LIMIT;
    cfg_data = '0;
    gaps_on = 1'b1;
    burst_left = 0;
    live_items = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: empty sum, zero ticks, a plain reading, ignored ticks on a
    // conversion, a saturated sum, and a sum of one that makes the products wrap.
    send_item(psv_pkg::CMD_CONVERT, 32'd0);
    send_item(psv_pkg::CMD_EDGE, 32'd0);
    send_item(psv_pkg::CMD_CONVERT, 32'd0);
    send_item(psv_pkg::CMD_EDGE, 32'd2233);
    send_item(psv_pkg::CMD_CONVERT, 32'hDEAD_BEEF);
    send_item(psv_pkg::CMD_EDGE, 32'hFFFF_FFFF);
    send_item(psv_pkg::CMD_EDGE, 32'hFFFF_FFFF);
    send_item(psv_pkg::CMD_CONVERT, 32'd0);
    send_item(psv_pkg::CMD_EDGE, 32'd1);
    send_item(psv_pkg::CMD_CONVERT, 32'd0);

    // The edge count is already past a limit of one, so gathering runs on; the divisor
    // is zero.
    quiesce();
    load_config(32'd1, CAL_MAX, CAL_MAX, CAL_MAX, 32'd0);
    send_item(psv_pkg::CMD_EDGE, 32'd1000);
    send_item(psv_pkg::CMD_EDGE, 32'd5);
    send_item(psv_pkg::CMD_CONVERT, 32'd0);

    quiesce();
    load_config(32'd5, psv_pkg::CAL_NUMERATOR_RST, 32'd0, 32'd1, 32'd1);
    repeat (3) send_item(psv_pkg::CMD_EDGE, 32'd7);
    send_item(psv_pkg::CMD_CONVERT, 32'd0);

    // The edge count is now above the new limit, so gathering runs on.
    quiesce();
    load_config(32'd2, psv_pkg::CAL_NUMERATOR_RST, CAL_MAX, 32'd0, CAL_MAX);
    send_item(psv_pkg::CMD_EDGE, 32'd12);
    send_item(psv_pkg::CMD_EDGE, 32'h8000_0000);
    send_item(psv_pkg::CMD_CONVERT, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      load_config((p == 0) ? LIMIT_MAX : pick_limit(),
                  (p == 0) ? CAL_MAX : pick_cal(psv_pkg::CAL_NUMERATOR_RST, 1'b0),
                  pick_cal(psv_pkg::CAL_OFFSET_RST, 1'b1),
                  pick_cal(psv_pkg::CAL_SLOPE_RST, 1'b1),
                  (p == 0) ? CAL_MAX : pick_cal(psv_pkg::CAL_DIVISOR_RST, 1'b0));
      gaps_on = (p % 4 != 1);
      // Keep offering transfers while the receiver holds off, so the core backs up.
      if (p == 2 || p == 7) begin
        holds_asked++;
        gaps_on = 1'b0;
      end
      target = live_items + ITEMS_PER_PHASE;
      while (live_items < target) run_sequence();
    end

    quiesce();
    if (sb.fails == 0) begin
      $display("** period_sum_voltage_readout_core: PASSED **");
    end else begin
      $display("** period_sum_voltage_readout_core: FAILED **");
    end
    $finish;
  end

endmodule
